@@ src/mesh_chunk_stream_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Mesh chunk stream parser assertion macros
// Concurrent assertion shorthands; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MESH_CHUNK_STREAM_PARSER_MACROS_SVH
`define MESH_CHUNK_STREAM_PARSER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MCSP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mesh chunk parser: same-cycle check failed");
// next-cycle implication
`define MCSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mesh chunk parser: next-cycle check failed");
`else
`define MCSP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MCSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/mcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Mesh chunk stream parser package
// Payload structs, parse phases, record kinds and chunk ids.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsp_pkg;

   // name chunk stops after this many bytes (1..31)
   localparam int NameLimit = 20;

   // header is 2 id bytes plus 4 length bytes
   localparam int HeaderSize = 6;

   localparam logic [15:0] ID_MAIN     = 16'h4d4d;
   localparam logic [15:0] ID_EDIT     = 16'h3d3d;
   localparam logic [15:0] ID_OBJECT   = 16'h4000;
   localparam logic [15:0] ID_TRIMESH  = 16'h4100;
   localparam logic [15:0] ID_VERTICES = 16'h4110;
   localparam logic [15:0] ID_FACES    = 16'h4120;
   localparam logic [15:0] ID_MAPPING  = 16'h4140;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_COUNT,
      PH_WORDS,
      PH_SKIP
   } parse_phase_type;

   typedef enum logic [2:0] {
      RK_NAME_BYTE,
      RK_VERTEX_COUNT,
      RK_VERTEX_COORD,
      RK_POLYGON_COUNT,
      RK_CORNER_INDEX,
      RK_MAP_COORD
   } record_kind_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_file;
   } req_payload_type;

   typedef struct packed {
      record_kind_type record_kind;
      logic [15:0]     element_index;
      logic [1:0]      component;
      logic [31:0]     record_value;
      logic            record_valid;
      logic            end_marker;
      logic            truncated;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ src/mesh_chunk_stream_parser.sv @@
// ----------------------------------------------------------------------------
// Mesh chunk stream parser
// Byte-serial chunk walker for mesh files; emits name, count and word records.
// ----------------------------------------------------------------------------
// Takes one file byte per transfer and, while req_stall is low, one byte every clock.
// Each byte is parsed by a single combinational pass over the parser state,
// and the record it causes (if any) is registered into the output or skid
// register. A byte that completes no record and is not the last byte
// of the file produces nothing; the last byte (end_of_file) always produces a
// result carrying end_marker, plus truncated when the file stopped inside a
// chunk or header. The output side is a two-entry buffer (output register plus
// skid register), so bytes keep flowing while one record waits on rsp_stall;
// req_stall rises only when both entries are occupied. After the last byte the
// parser is back at the start of a header, ready for the next file.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mesh_chunk_stream_parser_macros.svh"

module mesh_chunk_stream_parser
   import mcsp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   // parser state
   parse_phase_type phase_ff, phase_in;
   logic [2:0]      hdr_cnt_ff, hdr_cnt_in;
   logic [15:0]     id_ff, id_in;
   logic [31:0]     len_ff, len_in;
   logic [31:0]     skip_ff, skip_in;
   logic [15:0]     count_ff, count_in;
   logic [15:0]     pos_ff, pos_in;
   logic [1:0]      comp_ff, comp_in;
   logic [31:0]     word_ff, word_in;
   logic [1:0]      wbc_ff, wbc_in;
   logic [4:0]      name_cnt_ff, name_cnt_in;

   // output buffer
   rsp_payload_type out_ff, skid_ff;
   logic            out_valid_ff, skid_valid_ff;

   // step flags, shared by the datapath and next-phase logic
   logic            hdr_done, name_done, count_done, item_done, skip_done;
   logic            have;
   record_kind_type rec_kind;
   logic [15:0]     rec_idx;
   logic [1:0]      rec_comp;
   logic [31:0]     rec_val;

   logic            is_container, is_object, is_list;
   logic [31:0]     word_val;
   logic            word_last;
   logic [2:0]      comp_next;
   logic [2:0]      ncomp;
   record_kind_type word_kind;
   logic [31:0]     skip_dec;

   logic            req_accept, rsp_pop, eof;
   rsp_payload_type rsp_new;
   logic            rsp_new_valid;

   assign req_accept = req_valid && !req_stall;
   assign eof        = req_payload.end_of_file;

   // Chunk class of the current id; both id bytes are in place well before
   // the last header byte, which is the only time the class is used
   assign is_container = (id_ff == ID_MAIN) || (id_ff == ID_EDIT) || (id_ff == ID_TRIMESH);
   assign is_object    = (id_ff == ID_OBJECT);
   assign is_list      = (id_ff == ID_VERTICES) || (id_ff == ID_FACES) ||
                         (id_ff == ID_MAPPING);

   // Word shapes: faces are 16-bit words, four per polygon (flag dropped);
   // vertices are three floats, map points two floats.
   always_comb begin
      if (id_ff == ID_VERTICES) begin
         ncomp     = 3'd3;
         word_kind = RK_VERTEX_COORD;
      end else if (id_ff == ID_FACES) begin
         ncomp     = 3'd4;
         word_kind = RK_CORNER_INDEX;
      end else begin
         ncomp     = 3'd2;
         word_kind = RK_MAP_COORD;
      end
   end

   assign word_last = (id_ff == ID_FACES) ? (wbc_ff != 2'd0) : (wbc_ff == 2'd3);
   assign word_val  = (wbc_ff == 2'd0) ? {24'd0, req_payload.file_byte}
                    : (word_ff | ({24'd0, req_payload.file_byte} << {wbc_ff, 3'b000}));
   assign comp_next = {1'b0, comp_ff} + 3'd1;
   assign skip_dec  = (skip_ff != 32'd0) ? (skip_ff - 32'd1) : skip_ff;

   // Datapath: next values of counters, assembly registers and record fields
   always_comb begin
      hdr_cnt_in  = hdr_cnt_ff;
      id_in       = id_ff;
      len_in      = len_ff;
      skip_in     = skip_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      comp_in     = comp_ff;
      word_in     = word_ff;
      wbc_in      = wbc_ff;
      name_cnt_in = name_cnt_ff;
      hdr_done    = 1'b0;
      name_done   = 1'b0;
      count_done  = 1'b0;
      item_done   = 1'b0;
      skip_done   = 1'b0;
      have        = 1'b0;
      rec_kind    = RK_NAME_BYTE;
      rec_idx     = 16'd0;
      rec_comp    = 2'd0;
      rec_val     = 32'd0;
      case (phase_ff)
         PH_HEADER: begin
            case (hdr_cnt_ff)
               3'd0:    id_in        = {8'd0, req_payload.file_byte};
               3'd1:    id_in[15:8]  = req_payload.file_byte;
               3'd2:    len_in       = {24'd0, req_payload.file_byte};
               3'd3:    len_in[15:8] = req_payload.file_byte;
               3'd4:    len_in[23:16] = req_payload.file_byte;
               3'd5:    len_in[31:24] = req_payload.file_byte;
               default: ;
            endcase
            if (hdr_cnt_ff >= 3'(HeaderSize - 1)) begin
               hdr_done   = 1'b1;
               hdr_cnt_in = 3'd0;
               // chunk entry side effects
               if (is_container) begin
               end else if (is_object) begin
                  name_cnt_in = 5'd0;
               end else if (is_list) begin
                  word_in = 32'd0;
                  wbc_in  = 2'd0;
               end else begin
                  skip_in = (len_in >= 32'(HeaderSize)) ? (len_in - 32'(HeaderSize)) : 32'd0;
               end
            end else begin
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
            end
         end
         PH_NAME: begin
            have        = 1'b1;
            rec_kind    = RK_NAME_BYTE;
            rec_idx     = {11'd0, name_cnt_ff};
            rec_val     = {24'd0, req_payload.file_byte};
            name_cnt_in = name_cnt_ff + 5'd1;
            name_done   = (req_payload.file_byte == 8'd0) || (name_cnt_in >= 5'(NameLimit));
         end
         PH_COUNT: begin
            if (wbc_ff == 2'd0) begin
               word_in = {24'd0, req_payload.file_byte};
               wbc_in  = 2'd1;
            end else begin
               count_in   = {req_payload.file_byte, word_ff[7:0]};
               word_in    = 32'd0;
               wbc_in     = 2'd0;
               pos_in     = 16'd0;
               comp_in    = 2'd0;
               count_done = 1'b1;
               // map point count carries no record
               if (id_ff == ID_VERTICES) begin
                  have     = 1'b1;
                  rec_kind = RK_VERTEX_COUNT;
                  rec_val  = {16'd0, count_in};
               end else if (id_ff == ID_FACES) begin
                  have     = 1'b1;
                  rec_kind = RK_POLYGON_COUNT;
                  rec_val  = {16'd0, count_in};
               end
            end
         end
         PH_WORDS: begin
            if (word_last) begin
               wbc_in  = 2'd0;
               word_in = 32'd0;
               // fourth face word is the edge flag: consumed, not emitted
               if (comp_ff != 2'd3) begin
                  have     = 1'b1;
                  rec_kind = word_kind;
                  rec_idx  = pos_ff;
                  rec_comp = comp_ff;
                  rec_val  = word_val;
               end
               if (comp_next >= ncomp) begin
                  comp_in   = 2'd0;
                  pos_in    = pos_ff + 16'd1;
                  item_done = (pos_in == 16'd0) || (pos_in >= count_ff);
               end else begin
                  comp_in = comp_next[1:0];
               end
            end else begin
               wbc_in  = wbc_ff + 2'd1;
               word_in = word_val;
            end
         end
         PH_SKIP: begin
            skip_in   = skip_dec;
            skip_done = (skip_dec == 32'd0);
         end
         default: ;
      endcase
   end

   // Next parse phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (hdr_done) begin
               if (is_container) begin
                  phase_in = PH_HEADER;
               end else if (is_object) begin
                  phase_in = PH_NAME;
               end else if (is_list) begin
                  phase_in = PH_COUNT;
               end else begin
                  phase_in = (skip_in != 32'd0) ? PH_SKIP : PH_HEADER;
               end
            end
         end
         PH_NAME: begin
            if (name_done) phase_in = PH_HEADER;
         end
         PH_COUNT: begin
            if (count_done) phase_in = (count_in != 16'd0) ? PH_WORDS : PH_HEADER;
         end
         PH_WORDS: begin
            if (item_done) phase_in = PH_HEADER;
         end
         PH_SKIP: begin
            if (skip_done) phase_in = PH_HEADER;
         end
         default: phase_in = PH_HEADER;
      endcase
   end

   // Result of this byte; end byte without a record carries zero fields
   always_comb begin
      rsp_new.record_kind   = rec_kind;
      rsp_new.element_index = rec_idx;
      rsp_new.component     = rec_comp;
      rsp_new.record_value  = rec_val;
      rsp_new.record_valid  = have;
      rsp_new.end_marker    = eof;
      rsp_new.truncated     = eof && !((phase_in == PH_HEADER) && (hdr_cnt_in == 3'd0));
      rsp_new_valid         = have || eof;
   end

   // Parser control state; the end byte returns it to the header start
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= 3'd0;
         wbc_ff     <= 2'd0;
         comp_ff    <= 2'd0;
      end else if (req_accept) begin
         if (eof) begin
            phase_ff   <= PH_HEADER;
            hdr_cnt_ff <= 3'd0;
            wbc_ff     <= 2'd0;
            comp_ff    <= 2'd0;
         end else begin
            phase_ff   <= phase_in;
            hdr_cnt_ff <= hdr_cnt_in;
            wbc_ff     <= wbc_in;
            comp_ff    <= comp_in;
         end
      end
   end

   // Parser payload state: always written before it is read in a new chunk
   always_ff @(posedge clock) begin
      if (req_accept) begin
         id_ff       <= id_in;
         len_ff      <= len_in;
         skip_ff     <= skip_in;
         count_ff    <= count_in;
         pos_ff      <= pos_in;
         word_ff     <= word_in;
         name_cnt_ff <= name_cnt_in;
      end
   end

   // Output buffer: output register plus one skid entry.
   // Input stalls only when the skid entry holds a record.
   assign rsp_pop     = out_valid_ff && !rsp_stall;
   assign req_stall   = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_pop) skid_valid_ff <= 1'b0;
      end else if (req_accept && rsp_new_valid) begin
         if (!out_valid_ff || rsp_pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) out_ff <= skid_ff;
      end else if (req_accept && rsp_new_valid) begin
         if (!out_valid_ff || rsp_pop) begin
            out_ff <= rsp_new;
         end else begin
            skid_ff <= rsp_new;
         end
      end
   end

   // Checks
   `MCSP_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `MCSP_ASSERT_NEXT(a_eof_rearms, clock, reset, req_accept && eof,
      (phase_ff == PH_HEADER) && (hdr_cnt_ff == 3'd0))
   `MCSP_ASSERT_IMPLIES(a_skip_nonzero, clock, reset, phase_ff == PH_SKIP, skip_ff != 32'd0)
   `MCSP_ASSERT_IMPLIES(a_hdr_cnt_in_header, clock, reset, hdr_cnt_ff != 3'd0,
      (phase_ff == PH_HEADER) && (hdr_cnt_ff < 3'(HeaderSize)))

endmodule

`default_nettype wire
